[hw/rtl/csg_pkg.sv]
// ----------------------------------------------------------------------------
// csg_pkg
// Types, codes and constants shared by the circular setpoint generator.
// ----------------------------------------------------------------------------
package csg_pkg;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [23:0] target_speed;
	} in_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [31:0] vel_x;
		logic signed [31:0] vel_y;
		logic signed [31:0] acc_x;
		logic signed [31:0] acc_y;
		logic signed [31:0] jerk_x;
		logic signed [31:0] jerk_y;
		logic [31:0]        yaw_phase;
		logic [30:0]        yaw_rate;
		logic [1:0]         phase_code;
	} out_t;

	typedef struct packed {
		logic [30:0]        radius;
		logic [30:0]        inverse_radius;
		logic signed [31:0] center_x;
		logic signed [31:0] center_y;
		logic signed [31:0] altitude;
		logic [23:0]        speed_step;
		logic [31:0]        dt_turns;
		logic [15:0]        hold_ticks;
	} cfg_t;

	localparam logic [1:0] OP_TICK   = 2'd0;
	localparam logic [1:0] OP_TARGET = 2'd1;
	localparam logic [1:0] OP_BRAKE  = 2'd2;

	localparam logic [1:0] PC_ACCEL = 2'd0;
	localparam logic [1:0] PC_HOLD  = 2'd1;
	localparam logic [1:0] PC_BRAKE = 2'd2;
	localparam logic [1:0] PC_STOP  = 2'd3;

	localparam logic [2:0] CFG_RADIUS     = 3'd0;
	localparam logic [2:0] CFG_INV_RADIUS = 3'd1;
	localparam logic [2:0] CFG_CENTER_X   = 3'd2;
	localparam logic [2:0] CFG_CENTER_Y   = 3'd3;
	localparam logic [2:0] CFG_ALTITUDE   = 3'd4;
	localparam logic [2:0] CFG_SPEED_STEP = 3'd5;
	localparam logic [2:0] CFG_DT_TURNS   = 3'd6;
	localparam logic [2:0] CFG_HOLD_TICKS = 3'd7;

	localparam logic [31:0] CORDIC_GAIN  = 32'd652032874;
	localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
	localparam logic [62:0] SAT62        = 63'h4000_0000_0000_0000;

	// product sequence, in issue order
	typedef enum logic [3:0] {
		MO_OMEGA, MO_PHASE, MO_V2, MO_V2R, MO_T, MO_V3,
		MO_POSX, MO_POSY, MO_VELX, MO_VELY, MO_ACCX, MO_ACCY, MO_JERKX, MO_JERKY
	} mop_t;

	typedef struct packed {
		logic        mul_act;
		mop_t        mul_op;
		logic [1:0]  mul_phase;
		logic        cordic_init;
		logic        cordic_step;
		logic [4:0]  cordic_idx;
		logic        cordic_fin;
		logic        out_load;
		logic [1:0]  code;
		logic [23:0] speed;
	} cmd_t;

	typedef struct packed {
		logic out_full;
	} status_t;

	function automatic logic [31:0] atan_turns(input logic [4:0] i);
		logic [31:0] r;
		case (i)
			5'd0: r = 32'd536870912;
			5'd1: r = 32'd316933406;
			5'd2: r = 32'd167458907;
			5'd3: r = 32'd85004756;
			5'd4: r = 32'd42667331;
			5'd5: r = 32'd21354465;
			5'd6: r = 32'd10679838;
			5'd7: r = 32'd5340245;
			5'd8: r = 32'd2670163;
			5'd9: r = 32'd1335087;
			5'd10: r = 32'd667544;
			5'd11: r = 32'd333772;
			5'd12: r = 32'd166886;
			5'd13: r = 32'd83443;
			5'd14: r = 32'd41722;
			5'd15: r = 32'd20861;
			5'd16: r = 32'd10430;
			5'd17: r = 32'd5215;
			5'd18: r = 32'd2608;
			5'd19: r = 32'd1304;
			5'd20: r = 32'd652;
			5'd21: r = 32'd326;
			5'd22: r = 32'd163;
			5'd23: r = 32'd81;
			5'd24: r = 32'd41;
			5'd25: r = 32'd20;
			5'd26: r = 32'd10;
			5'd27: r = 32'd5;
			5'd28: r = 32'd3;
			5'd29: r = 32'd1;
			5'd30: r = 32'd1;
			default: r = 32'd0;
		endcase
		return r;
	endfunction

endpackage

[hw/rtl/csg_ctrl.sv]
// ----------------------------------------------------------------------------
// csg_ctrl
// Motion state machine (ramp, hold, brake) and sequencer for one setpoint.
// ----------------------------------------------------------------------------
module csg_ctrl #(
	parameter int ROTATION_STEPS = 24
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  csg_pkg::in_t     in_data,
	input  csg_pkg::cfg_t    cfg,
	input  logic             out_ready,
	input  csg_pkg::status_t status,
	output csg_pkg::cmd_t    cmd
);
	import csg_pkg::*;

	localparam logic [4:0] LAST_STEP = 5'(ROTATION_STEPS - 1);

	typedef enum logic [2:0] {ST_READY, ST_MUL, ST_CINIT, ST_CORDIC, ST_CFIN, ST_DONE} state_t;
	typedef enum logic [2:0] {M_IDLE, M_ACCEL, M_HOLD, M_BRAKE, M_STOPPED} mode_t;

	state_t      state_q;
	mode_t       mode_q;
	logic [23:0] speed_q;
	logic [23:0] goal_q;
	logic [15:0] hold_q;
	mop_t        op_q;
	logic [1:0]  phase_q;
	logic [4:0]  idx_q;
	logic [1:0]  code_q;

	logic [24:0] ramp_sum;
	logic [23:0] accel_speed;
	logic [23:0] brake_speed;
	logic        can_load;

	assign ramp_sum    = {1'b0, speed_q} + {1'b0, cfg.speed_step};
	assign accel_speed = (ramp_sum > {1'b0, goal_q}) ? goal_q : ramp_sum[23:0];
	assign brake_speed = (speed_q > cfg.speed_step) ? speed_q - cfg.speed_step : 24'd0;
	assign can_load    = !status.out_full || out_ready;

	assign in_ready = (state_q == ST_READY);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_READY;
			mode_q  <= M_IDLE;
			speed_q <= '0;
			goal_q  <= '0;
			hold_q  <= '0;
			op_q    <= MO_OMEGA;
			phase_q <= '0;
			idx_q   <= '0;
			code_q  <= PC_ACCEL;
		end else begin
			case (state_q)
				ST_READY: begin
					if (in_valid) begin
						case (in_data.opcode)
							OP_TARGET: begin
								goal_q <= in_data.target_speed;
								if (in_data.target_speed > speed_q) begin
									mode_q <= M_ACCEL;
								end else if (cfg.hold_ticks == 16'd0) begin
									mode_q <= M_BRAKE;
								end else begin
									hold_q <= cfg.hold_ticks;
									mode_q <= M_HOLD;
								end
							end
							OP_BRAKE: mode_q <= M_BRAKE;
							OP_TICK: begin
								case (mode_q)
									M_ACCEL: begin
										speed_q <= accel_speed;
										code_q  <= PC_ACCEL;
										state_q <= ST_MUL;
										op_q    <= MO_OMEGA;
										phase_q <= '0;
										if (accel_speed >= goal_q) begin
											if (cfg.hold_ticks == 16'd0) begin
												mode_q <= M_BRAKE;
											end else begin
												hold_q <= cfg.hold_ticks;
												mode_q <= M_HOLD;
											end
										end
									end
									M_HOLD: begin
										code_q  <= PC_HOLD;
										state_q <= ST_MUL;
										op_q    <= MO_OMEGA;
										phase_q <= '0;
										hold_q  <= hold_q - 16'd1;
										if (hold_q == 16'd1) mode_q <= M_BRAKE;
									end
									M_BRAKE: begin
										speed_q <= brake_speed;
										state_q <= ST_MUL;
										op_q    <= MO_OMEGA;
										phase_q <= '0;
										if (brake_speed == 24'd0) begin
											code_q <= PC_STOP;
											mode_q <= M_STOPPED;
										end else begin
											code_q <= PC_BRAKE;
										end
									end
									default: ;
								endcase
							end
							default: ;
						endcase
					end
				end
				ST_MUL: begin
					phase_q <= phase_q + 2'd1;
					if (phase_q == 2'd3) begin
						if (op_q == MO_PHASE) begin
							state_q <= ST_CINIT;
						end else if (op_q == MO_JERKY) begin
							state_q <= ST_DONE;
						end else begin
							op_q <= mop_t'(op_q + 4'd1);
						end
					end
				end
				ST_CINIT: begin
					idx_q   <= '0;
					state_q <= ST_CORDIC;
				end
				ST_CORDIC: begin
					if (idx_q == LAST_STEP) state_q <= ST_CFIN;
					else idx_q <= idx_q + 5'd1;
				end
				ST_CFIN: begin
					state_q <= ST_MUL;
					op_q    <= MO_V2;
					phase_q <= '0;
				end
				ST_DONE: begin
					if (can_load) state_q <= ST_READY;
				end
				default: state_q <= ST_READY;
			endcase
		end
	end

	always_comb begin
		cmd             = '0;
		cmd.mul_act     = (state_q == ST_MUL);
		cmd.mul_op      = op_q;
		cmd.mul_phase   = phase_q;
		cmd.cordic_init = (state_q == ST_CINIT);
		cmd.cordic_step = (state_q == ST_CORDIC);
		cmd.cordic_idx  = idx_q;
		cmd.cordic_fin  = (state_q == ST_CFIN);
		cmd.out_load    = (state_q == ST_DONE) && can_load;
		cmd.code        = code_q;
		cmd.speed       = speed_q;
	end

endmodule

[hw/rtl/csg_datapath.sv]
// ----------------------------------------------------------------------------
// csg_datapath
// Shared 32x32 multiplier, CORDIC rotator and output register.
// ----------------------------------------------------------------------------
module csg_datapath (
	input  logic             clk,
	input  logic             arst_n,
	input  csg_pkg::cmd_t    cmd,
	input  csg_pkg::cfg_t    cfg,
	input  logic             out_ready,
	output csg_pkg::status_t status,
	output logic             out_valid,
	output csg_pkg::out_t    out_data
);
	import csg_pkg::*;

	logic [63:0]        prod_q;
	logic [47:0]        lo_q;
	logic [62:0]        mag_q;
	logic [30:0]        omega_q;
	logic [31:0]        angle_q;
	logic [31:0]        v2_q;
	logic [46:0]        v2r_q;
	logic [54:0]        t_q;
	logic [62:0]        v3_q;
	logic signed [33:0] x_q, y_q, z_q;
	logic [1:0]         quad_q;
	logic signed [33:0] c_q, s_q;
	logic signed [31:0] posx_q, posy_q, velx_q, vely_q;
	logic signed [31:0] accx_q, accy_q, jerkx_q, jerky_q;
	out_t               out_q;
	logic               out_valid_q;

	// operand selection
	logic [63:0]        op_a;
	logic [31:0]        op_b;
	logic               sh30;
	logic               neg;
	logic signed [31:0] base;
	logic [33:0]        c_abs, s_abs;
	logic               c_neg, s_neg;

	assign c_neg = c_q[33];
	assign s_neg = s_q[33];
	assign c_abs = c_neg ? 34'(-c_q) : c_q;
	assign s_abs = s_neg ? 34'(-s_q) : s_q;

	always_comb begin
		op_a = '0;
		op_b = '0;
		sh30 = 1'b1;
		neg  = 1'b0;
		base = '0;
		case (cmd.mul_op)
			MO_OMEGA: begin
				op_a = 64'(cmd.speed); op_b = 32'(cfg.inverse_radius); sh30 = 1'b0;
			end
			MO_PHASE: begin
				op_a = 64'(omega_q); op_b = cfg.dt_turns; sh30 = 1'b0;
			end
			MO_V2: begin
				op_a = 64'(cmd.speed); op_b = 32'(cmd.speed); sh30 = 1'b0;
			end
			MO_V2R: begin
				op_a = 64'(v2_q); op_b = 32'(cfg.inverse_radius); sh30 = 1'b0;
			end
			MO_T: begin
				op_a = 64'(v2r_q); op_b = 32'(cmd.speed); sh30 = 1'b0;
			end
			MO_V3: begin
				op_a = 64'(t_q); op_b = 32'(cfg.inverse_radius); sh30 = 1'b0;
			end
			MO_POSX: begin
				op_a = 64'(cfg.radius); op_b = c_abs[31:0]; base = cfg.center_x; neg = c_neg;
			end
			MO_POSY: begin
				op_a = 64'(cfg.radius); op_b = s_abs[31:0]; base = cfg.center_y; neg = s_neg;
			end
			MO_VELX: begin
				op_a = 64'(cmd.speed); op_b = s_abs[31:0]; neg = !s_neg;
			end
			MO_VELY: begin
				op_a = 64'(cmd.speed); op_b = c_abs[31:0]; neg = c_neg;
			end
			MO_ACCX: begin
				op_a = 64'(v2r_q); op_b = c_abs[31:0]; neg = !c_neg;
			end
			MO_ACCY: begin
				op_a = 64'(v2r_q); op_b = s_abs[31:0]; neg = !s_neg;
			end
			MO_JERKX: begin
				op_a = 64'(v3_q); op_b = s_abs[31:0]; neg = s_neg;
			end
			MO_JERKY: begin
				op_a = 64'(v3_q); op_b = c_abs[31:0]; neg = !c_neg;
			end
			default: ;
		endcase
	end

	// low half of operand a first, then high half
	logic [31:0] mul_a;
	logic [63:0] prod;
	assign mul_a = (cmd.mul_phase == 2'd0) ? op_a[31:0] : op_a[63:32];
	assign prod  = 64'(mul_a) * 64'(op_b);

	// merge the two partial products, capped at 2^62
	logic [63:0] hi_shifted;
	logic [63:0] merged;
	logic        hi_over;
	logic [62:0] combined;
	always_comb begin
		if (sh30) begin
			hi_over    = prod_q > 64'h1000_0000_0000_0000;
			hi_shifted = {prod_q[61:0], 2'b00};
		end else begin
			hi_over    = prod_q > 64'h0000_4000_0000_0000;
			hi_shifted = {prod_q[47:0], 16'h0000};
		end
		merged = hi_shifted + 64'(lo_q);
		if (hi_over || merged > 64'(SAT62)) combined = SAT62;
		else combined = merged[62:0];
	end

	// signed result with saturation to 32 bits
	logic signed [64:0] acc;
	logic signed [31:0] sat_val;
	always_comb begin
		acc = neg ? 65'(base) - $signed({2'b00, mag_q}) : 65'(base) + $signed({2'b00, mag_q});
		if (acc > 65'sd2147483647) sat_val = 32'sh7fff_ffff;
		else if (acc < -65'sd2147483648) sat_val = 32'sh8000_0000;
		else sat_val = acc[31:0];
	end

	// cordic
	logic [31:0]        quad_sum;
	logic [1:0]         quad;
	logic [31:0]        z_init;
	logic signed [33:0] x_sh, y_sh, at;
	assign quad_sum = angle_q + 32'h2000_0000;
	assign quad     = quad_sum[31:30];
	assign z_init   = angle_q - {quad, 30'd0};
	assign x_sh     = x_q >>> cmd.cordic_idx;
	assign y_sh     = y_q >>> cmd.cordic_idx;
	assign at       = $signed({2'b00, atan_turns(cmd.cordic_idx)});

	// the angle is motion state and starts from zero after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_q <= '0;
		end else if (cmd.mul_act && cmd.mul_phase == 2'd3 && cmd.mul_op == MO_PHASE) begin
			angle_q <= angle_q + mag_q[31:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_act) begin
			case (cmd.mul_phase)
				2'd0: prod_q <= prod;
				2'd1: begin
					lo_q   <= sh30 ? 48'(prod_q >> 30) : prod_q[63:16];
					prod_q <= prod;
				end
				2'd2: mag_q <= combined;
				default: begin
					case (cmd.mul_op)
						MO_OMEGA: omega_q <= (mag_q > 63'h7fff_ffff) ? 31'h7fff_ffff : mag_q[30:0];
						MO_V2:    v2_q    <= mag_q[31:0];
						MO_V2R:   v2r_q   <= mag_q[46:0];
						MO_T:     t_q     <= mag_q[54:0];
						MO_V3:    v3_q    <= mag_q;
						MO_POSX:  posx_q  <= sat_val;
						MO_POSY:  posy_q  <= sat_val;
						MO_VELX:  velx_q  <= sat_val;
						MO_VELY:  vely_q  <= sat_val;
						MO_ACCX:  accx_q  <= sat_val;
						MO_ACCY:  accy_q  <= sat_val;
						MO_JERKX: jerkx_q <= sat_val;
						MO_JERKY: jerky_q <= sat_val;
						default: ;
					endcase
				end
			endcase
		end
		if (cmd.cordic_init) begin
			x_q    <= $signed({2'b00, CORDIC_GAIN});
			y_q    <= '0;
			z_q    <= 34'($signed(z_init));
			quad_q <= quad;
		end
		if (cmd.cordic_step) begin
			if (!z_q[33]) begin
				x_q <= x_q - y_sh;
				y_q <= y_q + x_sh;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + y_sh;
				y_q <= y_q - x_sh;
				z_q <= z_q + at;
			end
		end
		if (cmd.cordic_fin) begin
			case (quad_q)
				2'd0: begin c_q <= x_q;  s_q <= y_q;  end
				2'd1: begin c_q <= -y_q; s_q <= x_q;  end
				2'd2: begin c_q <= -x_q; s_q <= -y_q; end
				default: begin c_q <= y_q; s_q <= -x_q; end
			endcase
		end
		if (cmd.out_load) begin
			out_q.pos_x      <= posx_q;
			out_q.pos_y      <= posy_q;
			out_q.pos_z      <= cfg.altitude;
			out_q.vel_x      <= velx_q;
			out_q.vel_y      <= vely_q;
			out_q.acc_x      <= accx_q;
			out_q.acc_y      <= accy_q;
			out_q.jerk_x     <= jerkx_q;
			out_q.jerk_y     <= jerky_q;
			out_q.yaw_phase  <= angle_q + QUARTER_TURN;
			out_q.yaw_rate   <= omega_q;
			out_q.phase_code <= cmd.code;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid       = out_valid_q;
	assign out_data        = out_q;
	assign status.out_full = out_valid_q;

endmodule

[hw/rtl/circular_setpoint_generator.sv]
// ----------------------------------------------------------------------------
// circular_setpoint_generator
// Speed-ramped setpoints for motion on a circle, Q16.16 fixed point.
// ----------------------------------------------------------------------------
// in channel (in_valid/in_ready/in_data) takes one command per transaction:
// tick, new target speed, or start braking. a tick while moving produces one
// setpoint transaction on the out channel (out_valid/out_ready/out_data);
// commands, and ticks while idle or stopped, produce nothing and leave in_ready high.
// a moving tick runs 14 products through one shared 32x32 multiplier: the
// omega and phase products, then CORDIC init, ROTATION_STEPS rotation steps
// and quadrant fix-up, then the remaining products and a load into the output
// register. out_valid rises in the cycle after the load, as does in_ready.
// the result sits in an output register; if the receiver stalls, the next
// tick is still computed and waits only for that register to drain.
// configuration is a plain write port (cfg_we, cfg_index, cfg_data); write
// it only while no transaction is in flight (the block does not enforce it).
// arst_n clears the motion state to idle at zero speed and angle and loads
// the default register values.
// ----------------------------------------------------------------------------
module circular_setpoint_generator #(
	parameter int ROTATION_STEPS = 24
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  csg_pkg::in_t  in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output csg_pkg::out_t out_data,
	input  logic          cfg_we,
	input  logic [2:0]    cfg_index,
	input  logic [31:0]   cfg_data
);
	import csg_pkg::*;

	cfg_t    cfg_q;
	cmd_t    cmd;
	status_t status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.radius         <= 31'd65536;
			cfg_q.inverse_radius <= 31'd65536;
			cfg_q.center_x       <= '0;
			cfg_q.center_y       <= '0;
			cfg_q.altitude       <= 32'sd65536;
			cfg_q.speed_step     <= 24'd655;
			cfg_q.dt_turns       <= 32'd6835652;
			cfg_q.hold_ticks     <= 16'd1000;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_RADIUS:     cfg_q.radius         <= cfg_data[30:0];
				CFG_INV_RADIUS: cfg_q.inverse_radius <= cfg_data[30:0];
				CFG_CENTER_X:   cfg_q.center_x       <= cfg_data;
				CFG_CENTER_Y:   cfg_q.center_y       <= cfg_data;
				CFG_ALTITUDE:   cfg_q.altitude       <= cfg_data;
				CFG_SPEED_STEP: cfg_q.speed_step     <= cfg_data[23:0];
				CFG_DT_TURNS:   cfg_q.dt_turns       <= cfg_data;
				CFG_HOLD_TICKS: cfg_q.hold_ticks     <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	csg_ctrl #(
		.ROTATION_STEPS(ROTATION_STEPS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.cfg      (cfg_q),
		.out_ready(out_ready),
		.status   (status),
		.cmd      (cmd)
	);

	csg_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.cfg      (cfg_q),
		.out_ready(out_ready),
		.status   (status),
		.out_valid(out_valid),
		.out_data (out_data)
	);

	// a new setpoint never overwrites one that is still waiting
	a_load_safe: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!status.out_full || out_ready))
		else $error("setpoint loaded over a pending transaction");

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> out_valid)
		else $error("loaded setpoint not presented");

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !(cmd.mul_act || cmd.cordic_step || cmd.cordic_init || cmd.cordic_fin))
		else $error("input ready while a setpoint is in progress");

	// commands update state only and never start a setpoint
	a_cmd_quick: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && in_data.opcode != OP_TICK) |=> in_ready)
		else $error("command did not complete in one cycle");

endmodule
